// File: rtl/mia_pkg.sv
// Shared types, codes and the helper function of the masked identifier allocator.
package mia_pkg;

  localparam int unsigned WordW          = 32;
  localparam int unsigned TableDepthDef  = 64;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    TK_SEARCH  = 2'd0,
    TK_WRITE   = 2'd1,
    TK_RELEASE = 2'd2
  } tok_kind_e;

  typedef struct packed {
    logic             vld;
    tok_kind_e        kind;
    logic [WordW-1:0] value;
    logic             hit;
    logic             free_seen;
    logic             last;
    logic             claimed;
  } tok_t;

  // Adds one to the masked bit positions of v; the carry skips unmasked bits.
  function automatic logic [WordW-1:0] masked_step(input logic [WordW-1:0] v,
                                                   input logic [WordW-1:0] m);
    logic [WordW-1:0] filled;
    logic [WordW-1:0] sum;
    filled = v | ~m;
    sum    = filled + WordW'(1);
    return (v & ~m) | (sum & m);
  endfunction

endpackage

// File: rtl/mia_cell.sv
// One table entry of the allocator chain, with the token register to its neighbor.
module mia_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flush_i,
  input  logic          clear_i,
  input  mia_pkg::tok_t tok_i,
  output mia_pkg::tok_t tok_o
);

  logic                      vld_q, vld_d;
  logic [mia_pkg::WordW-1:0] val_q, val_d;
  mia_pkg::tok_t             tok_q, tok_d;
  logic                      match;

  assign match = vld_q && (val_q == tok_i.value);

  always_comb begin
    tok_d = tok_i;
    vld_d = vld_q;
    val_d = val_q;
    if (tok_i.vld) begin
      case (tok_i.kind)
        mia_pkg::TK_SEARCH: begin
          if (match) tok_d.hit = 1'b1;
          if (!vld_q) tok_d.free_seen = 1'b1;
        end
        mia_pkg::TK_WRITE: begin
          if (!vld_q && !tok_i.claimed) begin
            vld_d         = 1'b1;
            val_d         = tok_i.value;
            tok_d.claimed = 1'b1;
          end
        end
        mia_pkg::TK_RELEASE: begin
          if (match) vld_d = 1'b0;
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
    if (clear_i) vld_d = 1'b0;
    tok_d.vld = tok_i.vld & ~flush_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      vld_q <= vld_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/masked_id_allocator.sv
// Top level of the masked identifier allocator: request control and the cell chain.
//
// A request is taken when start is high and busy is low. mode_i selects
// allocate, release or clear; alloc_mask_i and mark_value_i come with it.
// Every request gives exactly one result beat: done_o is high for one cycle
// with result_mark_o and status_o. The receiver cannot stall the block.
// The table lives in a chain of TABLE_DEPTH cells. A token enters the first
// cell and moves one cell per cycle. An allocation feeds one candidate per
// cycle into the chain, up to TABLE_DEPTH+1 of them. Candidates are judged
// as they leave the last cell; a free one then sends a write token down the
// chain, and the result beat is taken when that token leaves the chain.
// A release sends its token down the chain and ends when it leaves it; a
// clear or an unused mode needs no pass. The block works on one request at a
// time; the next request can be taken at the edge that takes the result beat.
// Reset empties the table and sets the last-given counter to one.
module masked_id_allocator #(
  parameter int unsigned TABLE_DEPTH = mia_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode_i,
  input  logic [mia_pkg::WordW-1:0] alloc_mask_i,
  input  logic [mia_pkg::WordW-1:0] mark_value_i,
  output logic                      done_o,
  output logic [mia_pkg::WordW-1:0] result_mark_o,
  output logic [1:0]                status_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE,
    S_WAIT
  } state_e;

  state_e                    state_q;
  logic [mia_pkg::WordW-1:0] last_q;
  logic [mia_pkg::WordW-1:0] mask_q;
  logic [mia_pkg::WordW-1:0] cand_q;
  logic [CntW-1:0]           cnt_q;
  logic [mia_pkg::WordW-1:0] result_q;
  logic [1:0]                status_q;
  logic                      done_q;

  mia_pkg::tok_t tok [TABLE_DEPTH+1];
  mia_pkg::tok_t tok_head;
  mia_pkg::tok_t tok_exit;
  logic          flush;
  logic          clear;
  logic          accept;

  assign accept   = start && (state_q == S_IDLE);
  assign tok_exit = tok[TABLE_DEPTH];
  assign flush    = (state_q == S_SEARCH) && tok_exit.vld && !tok_exit.hit;
  assign clear    = accept && (mode_i == mia_pkg::MODE_CLEAR);

  always_comb begin
    tok_head = '0;
    if (accept && (mode_i == mia_pkg::MODE_RELEASE)) begin
      tok_head.vld   = 1'b1;
      tok_head.kind  = mia_pkg::TK_RELEASE;
      tok_head.value = mark_value_i;
    end else if ((state_q == S_SEARCH) && (cnt_q <= CntW'(TABLE_DEPTH))) begin
      tok_head.vld   = 1'b1;
      tok_head.kind  = mia_pkg::TK_SEARCH;
      tok_head.value = cand_q;
      tok_head.last  = (cnt_q == CntW'(TABLE_DEPTH));
    end else if (state_q == S_WRITE) begin
      tok_head.vld   = 1'b1;
      tok_head.kind  = mia_pkg::TK_WRITE;
      tok_head.value = result_q;
    end
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mia_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flush_i (flush),
      .clear_i (clear),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      last_q   <= mia_pkg::WordW'(1);
      mask_q   <= '0;
      cand_q   <= '0;
      cnt_q    <= '0;
      result_q <= '0;
      status_q <= mia_pkg::ST_OK;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            result_q <= '0;
            status_q <= mia_pkg::ST_OK;
            case (mode_i)
              mia_pkg::MODE_ALLOC: begin
                mask_q  <= alloc_mask_i;
                cand_q  <= mia_pkg::masked_step(last_q & alloc_mask_i, alloc_mask_i);
                cnt_q   <= '0;
                state_q <= S_SEARCH;
              end
              mia_pkg::MODE_RELEASE: begin
                state_q <= S_WAIT;
              end
              mia_pkg::MODE_CLEAR: begin
                last_q <= mia_pkg::WordW'(1);
                done_q <= 1'b1;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (cnt_q <= CntW'(TABLE_DEPTH)) begin
            cand_q <= mia_pkg::masked_step(cand_q, mask_q);
            cnt_q  <= cnt_q + CntW'(1);
          end
          if (tok_exit.vld) begin
            if (!tok_exit.hit) begin
              if (!tok_exit.free_seen) begin
                status_q <= mia_pkg::ST_FULL;
                done_q   <= 1'b1;
                state_q  <= S_IDLE;
              end else begin
                result_q <= tok_exit.value;
                last_q   <= tok_exit.value;
                state_q  <= S_WRITE;
              end
            end else if (tok_exit.last) begin
              status_q <= mia_pkg::ST_EXHAUSTED;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (tok_exit.vld) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign result_mark_o = result_q;
  assign status_o      = status_q;

endmodule
